[design/sms_pkg.sv]
// Shared types, constants and the finishing microprogram of the moment statistics unit.
package sms_pkg;

  localparam int W       = 256;
  localparam int CNTW    = 8;
  localparam int PCW     = 7;
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(W - 1);
  localparam logic [CNTW-1:0] SQ_LAST  = CNTW'(W / 2 - 1);
  localparam logic [PCW-1:0]  PROG_LAST = 7'd107;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ, ST_CUBE, ST_QUAD, ST_FOURTH, ST_FETCH, ST_EXEC
  } state_t;

  typedef enum logic [3:0] {
    OP_LDA, OP_LDI, OP_ADD, OP_SUB, OP_SHL, OP_SHR, OP_ABS,
    OP_CNEG, OP_ZTST, OP_MUL, OP_DIV, OP_SQRT, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] dst;
    logic [3:0] ra;
    logic [3:0] rb;
    logic [7:0] imm;
  } instr_t;

  // accumulator sources for OP_LDA
  localparam logic [7:0] SRC_N   = 8'd0;
  localparam logic [7:0] SRC_S1  = 8'd1;
  localparam logic [7:0] SRC_S2  = 8'd2;
  localparam logic [7:0] SRC_S3  = 8'd3;
  localparam logic [7:0] SRC_S4  = 8'd4;
  localparam logic [7:0] SRC_MIN = 8'd5;
  localparam logic [7:0] SRC_MAX = 8'd6;

  // statistic indexes
  localparam logic [2:0] IDX_MIN  = 3'd0;
  localparam logic [2:0] IDX_MAX  = 3'd1;
  localparam logic [2:0] IDX_MEAN = 3'd2;
  localparam logic [2:0] IDX_VAR  = 3'd3;
  localparam logic [2:0] IDX_STD  = 3'd4;
  localparam logic [2:0] IDX_SKEW = 3'd5;
  localparam logic [2:0] IDX_KURT = 3'd6;

  localparam logic [3:0] R0  = 4'd0;
  localparam logic [3:0] R1  = 4'd1;
  localparam logic [3:0] R2  = 4'd2;
  localparam logic [3:0] R3  = 4'd3;
  localparam logic [3:0] R4  = 4'd4;
  localparam logic [3:0] R5  = 4'd5;
  localparam logic [3:0] R6  = 4'd6;
  localparam logic [3:0] R7  = 4'd7;
  localparam logic [3:0] R8  = 4'd8;
  localparam logic [3:0] R9  = 4'd9;
  localparam logic [3:0] R10 = 4'd10;
  localparam logic [3:0] R11 = 4'd11;
  localparam logic [3:0] R12 = 4'd12;
  localparam logic [3:0] R13 = 4'd13;
  localparam logic [3:0] R14 = 4'd14;

  function automatic instr_t mk(op_t op, logic [3:0] d, logic [3:0] a, logic [3:0] b,
                                logic [7:0] imm);
    instr_t i;
    i.op  = op;
    i.dst = d;
    i.ra  = a;
    i.rb  = b;
    i.imm = imm;
    return i;
  endfunction

  // Finishing program: R0 n, R1..R4 power sums, R6 D2, R7 n(n-1), R8 n^2,
  // R10 S1^2, R12 D2^2. Rounded divide = abs, 2|x|+d, / 2d, restore sign.
  function automatic instr_t prog(logic [PCW-1:0] pc, logic [7:0] fb);
    logic [7:0] fb2;
    instr_t     p;
    fb2 = {fb[6:0], 1'b0} + 8'd2;
    unique case (pc)
      7'd0:   p = mk(OP_LDA,  R5,  R0,  R0,  SRC_MIN);
      7'd1:   p = mk(OP_SHL,  R5,  R5,  R0,  fb);
      7'd2:   p = mk(OP_OUT,  R0,  R5,  R0,  {5'd0, IDX_MIN});
      7'd3:   p = mk(OP_LDA,  R5,  R0,  R0,  SRC_MAX);
      7'd4:   p = mk(OP_SHL,  R5,  R5,  R0,  fb);
      7'd5:   p = mk(OP_OUT,  R0,  R5,  R0,  {5'd0, IDX_MAX});
      7'd6:   p = mk(OP_LDA,  R0,  R0,  R0,  SRC_N);
      7'd7:   p = mk(OP_LDA,  R1,  R0,  R0,  SRC_S1);
      7'd8:   p = mk(OP_LDA,  R2,  R0,  R0,  SRC_S2);
      7'd9:   p = mk(OP_LDA,  R3,  R0,  R0,  SRC_S3);
      7'd10:  p = mk(OP_LDA,  R4,  R0,  R0,  SRC_S4);
      7'd11:  p = mk(OP_SHL,  R5,  R1,  R0,  fb);
      7'd12:  p = mk(OP_ABS,  R5,  R5,  R0,  8'd0);
      7'd13:  p = mk(OP_SHL,  R5,  R5,  R0,  8'd1);
      7'd14:  p = mk(OP_ADD,  R5,  R5,  R0,  8'd0);
      7'd15:  p = mk(OP_SHL,  R6,  R0,  R0,  8'd1);
      7'd16:  p = mk(OP_DIV,  R5,  R5,  R6,  8'd0);
      7'd17:  p = mk(OP_CNEG, R5,  R5,  R0,  8'd0);
      7'd18:  p = mk(OP_OUT,  R0,  R5,  R0,  {5'd0, IDX_MEAN});
      7'd19:  p = mk(OP_MUL,  R6,  R0,  R2,  8'd0);
      7'd20:  p = mk(OP_MUL,  R7,  R1,  R1,  8'd0);
      7'd21:  p = mk(OP_SUB,  R6,  R6,  R7,  8'd0);
      7'd22:  p = mk(OP_ZTST, R0,  R6,  R0,  8'd0);
      7'd23:  p = mk(OP_LDI,  R7,  R0,  R0,  8'd1);
      7'd24:  p = mk(OP_SUB,  R7,  R0,  R7,  8'd0);
      7'd25:  p = mk(OP_MUL,  R7,  R0,  R7,  8'd0);
      7'd26:  p = mk(OP_SHL,  R8,  R6,  R0,  fb);
      7'd27:  p = mk(OP_ABS,  R8,  R8,  R0,  8'd0);
      7'd28:  p = mk(OP_SHL,  R8,  R8,  R0,  8'd1);
      7'd29:  p = mk(OP_ADD,  R8,  R8,  R7,  8'd0);
      7'd30:  p = mk(OP_SHL,  R9,  R7,  R0,  8'd1);
      7'd31:  p = mk(OP_DIV,  R8,  R8,  R9,  8'd0);
      7'd32:  p = mk(OP_CNEG, R8,  R8,  R0,  8'd0);
      7'd33:  p = mk(OP_OUT,  R0,  R8,  R0,  {5'd0, IDX_VAR});
      7'd34:  p = mk(OP_SHL,  R8,  R6,  R0,  fb2);
      7'd35:  p = mk(OP_DIV,  R8,  R8,  R7,  8'd0);
      7'd36:  p = mk(OP_SQRT, R8,  R8,  R0,  8'd0);
      7'd37:  p = mk(OP_LDI,  R9,  R0,  R0,  8'd1);
      7'd38:  p = mk(OP_ADD,  R8,  R8,  R9,  8'd0);
      7'd39:  p = mk(OP_SHR,  R8,  R8,  R0,  8'd1);
      7'd40:  p = mk(OP_OUT,  R0,  R8,  R0,  {5'd0, IDX_STD});
      7'd41:  p = mk(OP_MUL,  R8,  R0,  R0,  8'd0);
      7'd42:  p = mk(OP_MUL,  R9,  R8,  R3,  8'd0);
      7'd43:  p = mk(OP_LDI,  R10, R0,  R0,  8'd3);
      7'd44:  p = mk(OP_MUL,  R10, R10, R0,  8'd0);
      7'd45:  p = mk(OP_MUL,  R11, R1,  R2,  8'd0);
      7'd46:  p = mk(OP_MUL,  R10, R10, R11, 8'd0);
      7'd47:  p = mk(OP_SUB,  R9,  R9,  R10, 8'd0);
      7'd48:  p = mk(OP_MUL,  R10, R1,  R1,  8'd0);
      7'd49:  p = mk(OP_MUL,  R11, R1,  R10, 8'd0);
      7'd50:  p = mk(OP_SHL,  R11, R11, R0,  8'd1);
      7'd51:  p = mk(OP_ADD,  R9,  R9,  R11, 8'd0);
      7'd52:  p = mk(OP_ABS,  R9,  R9,  R0,  8'd0);
      7'd53:  p = mk(OP_MUL,  R9,  R9,  R9,  8'd0);
      7'd54:  p = mk(OP_MUL,  R9,  R9,  R7,  8'd0);
      7'd55:  p = mk(OP_SHL,  R9,  R9,  R0,  fb2);
      7'd56:  p = mk(OP_LDI,  R11, R0,  R0,  8'd2);
      7'd57:  p = mk(OP_SUB,  R11, R0,  R11, 8'd0);
      7'd58:  p = mk(OP_MUL,  R11, R11, R11, 8'd0);
      7'd59:  p = mk(OP_MUL,  R11, R11, R6,  8'd0);
      7'd60:  p = mk(OP_MUL,  R12, R6,  R6,  8'd0);
      7'd61:  p = mk(OP_MUL,  R11, R11, R12, 8'd0);
      7'd62:  p = mk(OP_DIV,  R9,  R9,  R11, 8'd0);
      7'd63:  p = mk(OP_SQRT, R9,  R9,  R0,  8'd0);
      7'd64:  p = mk(OP_LDI,  R11, R0,  R0,  8'd1);
      7'd65:  p = mk(OP_ADD,  R9,  R9,  R11, 8'd0);
      7'd66:  p = mk(OP_SHR,  R9,  R9,  R0,  8'd1);
      7'd67:  p = mk(OP_CNEG, R9,  R9,  R0,  8'd0);
      7'd68:  p = mk(OP_OUT,  R0,  R9,  R0,  {5'd0, IDX_SKEW});
      7'd69:  p = mk(OP_MUL,  R9,  R8,  R0,  8'd0);
      7'd70:  p = mk(OP_MUL,  R9,  R9,  R4,  8'd0);
      7'd71:  p = mk(OP_MUL,  R11, R1,  R3,  8'd0);
      7'd72:  p = mk(OP_SHL,  R11, R11, R0,  8'd2);
      7'd73:  p = mk(OP_MUL,  R11, R8,  R11, 8'd0);
      7'd74:  p = mk(OP_SUB,  R9,  R9,  R11, 8'd0);
      7'd75:  p = mk(OP_MUL,  R11, R10, R2,  8'd0);
      7'd76:  p = mk(OP_LDI,  R13, R0,  R0,  8'd6);
      7'd77:  p = mk(OP_MUL,  R13, R13, R0,  8'd0);
      7'd78:  p = mk(OP_MUL,  R11, R13, R11, 8'd0);
      7'd79:  p = mk(OP_ADD,  R9,  R9,  R11, 8'd0);
      7'd80:  p = mk(OP_MUL,  R11, R10, R10, 8'd0);
      7'd81:  p = mk(OP_LDI,  R13, R0,  R0,  8'd3);
      7'd82:  p = mk(OP_MUL,  R11, R13, R11, 8'd0);
      7'd83:  p = mk(OP_SUB,  R9,  R9,  R11, 8'd0);
      7'd84:  p = mk(OP_LDI,  R13, R0,  R0,  8'd1);
      7'd85:  p = mk(OP_ADD,  R14, R0,  R13, 8'd0);
      7'd86:  p = mk(OP_SUB,  R13, R0,  R13, 8'd0);
      7'd87:  p = mk(OP_MUL,  R14, R14, R13, 8'd0);
      7'd88:  p = mk(OP_MUL,  R9,  R14, R9,  8'd0);
      7'd89:  p = mk(OP_MUL,  R14, R13, R13, 8'd0);
      7'd90:  p = mk(OP_LDI,  R13, R0,  R0,  8'd3);
      7'd91:  p = mk(OP_MUL,  R14, R13, R14, 8'd0);
      7'd92:  p = mk(OP_MUL,  R14, R14, R12, 8'd0);
      7'd93:  p = mk(OP_SUB,  R9,  R9,  R14, 8'd0);
      7'd94:  p = mk(OP_LDI,  R13, R0,  R0,  8'd2);
      7'd95:  p = mk(OP_SUB,  R14, R0,  R13, 8'd0);
      7'd96:  p = mk(OP_LDI,  R13, R0,  R0,  8'd3);
      7'd97:  p = mk(OP_SUB,  R13, R0,  R13, 8'd0);
      7'd98:  p = mk(OP_MUL,  R14, R14, R13, 8'd0);
      7'd99:  p = mk(OP_MUL,  R14, R14, R12, 8'd0);
      7'd100: p = mk(OP_SHL,  R9,  R9,  R0,  fb);
      7'd101: p = mk(OP_ABS,  R9,  R9,  R0,  8'd0);
      7'd102: p = mk(OP_SHL,  R9,  R9,  R0,  8'd1);
      7'd103: p = mk(OP_ADD,  R9,  R9,  R14, 8'd0);
      7'd104: p = mk(OP_SHL,  R14, R14, R0,  8'd1);
      7'd105: p = mk(OP_DIV,  R9,  R9,  R14, 8'd0);
      7'd106: p = mk(OP_CNEG, R9,  R9,  R0,  8'd0);
      default: p = mk(OP_OUT, R0,  R9,  R0,  {5'd0, IDX_KURT});
    endcase
    return p;
  endfunction

endpackage

[design/sample_moment_statistics_unit.sv]
// Sample moment statistics: accumulation of power sums and microcoded finishing unit.
// Each sample is accepted, then folded in by four power-sum steps before the next one is taken.
// After the last sample the finishing program runs 32 multiplies, 5 divides, 2 square roots
//   and its other steps one after another on the shared bit-serial unit.
// Each result transaction leaves through one output register as soon as it is computed;
//   the program holds on that step while the register is still full and tready is low.
// Reset (rst_n low, synchronous) clears count and sums, sets min/max to their extremes.
// After the seventh result the accumulators clear and the next set can start.
module sample_moment_statistics_unit #(
  parameter int MAX_SAMPLES   = 1024,
  parameter int SAMPLE_BITS   = 12,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] sample, [15:12] zero
  input  logic        in_tlast,   // last_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] stat_value
  output logic [3:0]  out_tuser,  // [2:0] stat_index, [3] status
  output logic        out_tlast   // last_result
);
  import sms_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int S1W = SB + CW;
  localparam int S2W = 2 * SB + CW;
  localparam int S3W = 3 * SB + CW;
  localparam int S4W = 4 * SB + CW;
  localparam int PW  = 4 * SB;

  // ---------------- control and accumulation state ----------------
  state_t state_r, state_nxt;

  logic [CW-1:0]         count_r, count_nxt;
  logic signed [SB-1:0]  min_r, min_nxt, max_r, max_nxt;
  logic signed [S1W-1:0] s1_r, s1_nxt;
  logic signed [S2W-1:0] s2_r, s2_nxt;
  logic signed [S3W-1:0] s3_r, s3_nxt;
  logic signed [S4W-1:0] s4_r, s4_nxt;

  // sample being folded in, its power, and whether it counts
  logic signed [SB-1:0]   x_r;
  logic                   last_r;
  logic                   take_r;
  logic signed [PW-1:0]   p_r, p_nxt;
  logic signed [2*SB-1:0] x_sq;
  logic signed [5*SB-1:0] p_x;

  // ---------------- finishing unit ----------------
  logic [PCW-1:0]  pc_r, pc_nxt;
  instr_t          ins_r, ins_fetch;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]    opa_r, opa_nxt, opb_r, opb_nxt, acc_r, acc_nxt;
  logic            sgn_r, sgn_nxt, zero_r, zero_nxt;
  logic [W-1:0]    rf_mem [16];
  logic            rf_we;
  logic [W-1:0]    rf_wdata;
  logic            op_done;

  // shared datapath terms
  logic [W-1:0]    sum_w, diff_w, neg_w, div_sh, sq_bit, sq_t, ld_w;
  logic            div_ge, sq_ge;
  logic [CNTW-1:0] sq_sh;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic [63:0] out_val_r, out_val_nxt;
  logic        out_undef_r, out_undef_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_free;
  logic        undef;
  logic        final_out;

  logic n_ge1, n_ge2, n_ge3, n_ge4, pos;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = {out_undef_r, out_idx_r};
  assign out_tlast  = out_last_r;

  assign ins_fetch = prog(pc_r, 8'(FRACTION_BITS));

  // power chain on two small multipliers: x^2, then times x twice
  assign x_sq = x_r * x_r;
  assign p_x  = p_r * x_r;

  // shared wide unit
  assign sum_w  = opa_r + opb_r;
  assign diff_w = opa_r - opb_r;
  assign neg_w  = -opa_r;
  assign div_sh = {acc_r[W-2:0], opa_r[W-1]};
  assign div_ge = (div_sh >= opb_r);
  // square root trial bit walks down from 2^(W-2) by two places per step
  assign sq_sh  = CNTW'(W - 2) - {cnt_r[CNTW-2:0], 1'b0};
  assign sq_bit = W'(1) << sq_sh;
  assign sq_t   = acc_r + sq_bit;
  assign sq_ge  = (opa_r >= sq_t);

  assign n_ge1 = (count_r >= CW'(1));
  assign n_ge2 = (count_r >= CW'(2));
  assign n_ge3 = (count_r >= CW'(3));
  assign n_ge4 = (count_r >= CW'(4));
  assign pos   = n_ge2 && !zero_r;

  assign out_free  = !out_valid_r || out_tready;
  assign final_out = (ins_r.op == OP_OUT) && (ins_r.imm[2:0] == IDX_KURT);

  // accumulator source for loads into the register file
  always_comb begin
    unique case (ins_r.imm)
      SRC_N:   ld_w = W'(count_r);
      SRC_S1:  ld_w = W'(s1_r);
      SRC_S2:  ld_w = W'(s2_r);
      SRC_S3:  ld_w = W'(s3_r);
      SRC_S4:  ld_w = W'(s4_r);
      SRC_MIN: ld_w = W'(min_r);
      SRC_MAX: ld_w = W'(max_r);
      default: ld_w = '0;
    endcase
  end

  // which statistics need more samples or a nonzero variance
  always_comb begin
    unique case (ins_r.imm[2:0])
      IDX_MIN, IDX_MAX, IDX_MEAN: undef = !n_ge1;
      IDX_VAR, IDX_STD:           undef = !n_ge2;
      IDX_SKEW:                   undef = !(n_ge3 && pos);
      IDX_KURT:                   undef = !(n_ge4 && pos);
      default:                    undef = 1'b1;
    endcase
  end

  // completion of the current instruction
  always_comb begin
    unique case (ins_r.op)
      OP_MUL, OP_DIV: op_done = (cnt_r == CNT_LAST);
      OP_SQRT:        op_done = (cnt_r == SQ_LAST);
      OP_OUT:         op_done = out_free;
      default:        op_done = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) begin
        state_nxt = ST_SQ;
      end
      ST_SQ:     state_nxt = ST_CUBE;
      ST_CUBE:   state_nxt = ST_QUAD;
      ST_QUAD:   state_nxt = ST_FOURTH;
      ST_FOURTH: state_nxt = last_r ? ST_FETCH : ST_IDLE;
      ST_FETCH:  state_nxt = ST_EXEC;
      ST_EXEC:   if (op_done) begin
        state_nxt = final_out ? ST_IDLE : ST_FETCH;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt     = count_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    s1_nxt        = s1_r;
    s2_nxt        = s2_r;
    s3_nxt        = s3_r;
    s4_nxt        = s4_r;
    p_nxt         = p_r;
    pc_nxt        = pc_r;
    cnt_nxt       = '0;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    acc_nxt       = acc_r;
    sgn_nxt       = sgn_r;
    zero_nxt      = zero_r;
    rf_we         = 1'b0;
    rf_wdata      = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_undef_nxt = out_undef_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_SQ: begin
        p_nxt = PW'(x_sq);
        if (take_r) begin
          count_nxt = count_r + CW'(1);
          s1_nxt    = s1_r + S1W'(x_r);
          if (x_r < min_r) begin
            min_nxt = x_r;
          end
          if (x_r > max_r) begin
            max_nxt = x_r;
          end
        end
      end
      ST_CUBE: begin
        p_nxt = p_x[PW-1:0];
        if (take_r) begin
          s2_nxt = s2_r + S2W'(p_r);
        end
      end
      ST_QUAD: begin
        p_nxt = p_x[PW-1:0];
        if (take_r) begin
          s3_nxt = s3_r + S3W'(p_r);
        end
      end
      ST_FOURTH: begin
        if (take_r) begin
          s4_nxt = s4_r + S4W'(p_r);
        end
        pc_nxt = '0;
      end
      ST_FETCH: begin
        acc_nxt = '0;
      end
      ST_EXEC: begin
        unique case (ins_r.op)
          OP_LDA:  begin rf_we = 1'b1; rf_wdata = ld_w; end
          OP_LDI:  begin rf_we = 1'b1; rf_wdata = W'(ins_r.imm); end
          OP_ADD:  begin rf_we = 1'b1; rf_wdata = sum_w; end
          OP_SUB:  begin rf_we = 1'b1; rf_wdata = diff_w; end
          OP_SHL:  begin rf_we = 1'b1; rf_wdata = opa_r << ins_r.imm; end
          OP_SHR:  begin rf_we = 1'b1; rf_wdata = opa_r >> ins_r.imm; end
          OP_ABS: begin
            rf_we    = 1'b1;
            rf_wdata = opa_r[W-1] ? neg_w : opa_r;
            sgn_nxt  = opa_r[W-1];
          end
          OP_CNEG: begin
            rf_we    = 1'b1;
            rf_wdata = sgn_r ? neg_w : opa_r;
          end
          OP_ZTST: zero_nxt = (opa_r == '0);
          OP_MUL: begin
            // shift-add, one multiplier bit per cycle
            acc_nxt  = opb_r[0] ? acc_r + opa_r : acc_r;
            opa_nxt  = opa_r << 1;
            opb_nxt  = opb_r >> 1;
            rf_wdata = acc_nxt;
          end
          OP_DIV: begin
            // restoring divide, one quotient bit per cycle
            acc_nxt  = div_ge ? div_sh - opb_r : div_sh;
            opa_nxt  = {opa_r[W-2:0], div_ge};
            rf_wdata = opa_nxt;
          end
          OP_SQRT: begin
            opa_nxt  = sq_ge ? opa_r - sq_t : opa_r;
            acc_nxt  = sq_ge ? (acc_r >> 1) + sq_bit : acc_r >> 1;
            rf_wdata = acc_nxt;
          end
          OP_OUT: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_idx_nxt   = ins_r.imm[2:0];
              out_val_nxt   = undef ? 64'd0 : opa_r[63:0];
              out_undef_nxt = undef;
              out_last_nxt  = final_out;
            end
          end
          default: rf_we = 1'b0;
        endcase

        if (ins_r.op == OP_MUL || ins_r.op == OP_DIV || ins_r.op == OP_SQRT) begin
          rf_we   = op_done;
          cnt_nxt = op_done ? '0 : cnt_r + CNTW'(1);
        end

        if (op_done) begin
          pc_nxt = pc_r + PCW'(1);
          if (final_out) begin
            // drop the finished set
            count_nxt = '0;
            min_nxt   = {1'b0, {(SB-1){1'b1}}};
            max_nxt   = {1'b1, {(SB-1){1'b0}}};
            s1_nxt    = '0;
            s2_nxt    = '0;
            s3_nxt    = '0;
            s4_nxt    = '0;
          end
        end
      end
      default: pc_nxt = pc_r;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      min_r       <= {1'b0, {(SB-1){1'b1}}};
      max_r       <= {1'b1, {(SB-1){1'b0}}};
      s1_r        <= '0;
      s2_r        <= '0;
      s3_r        <= '0;
      s4_r        <= '0;
      pc_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      s1_r        <= s1_nxt;
      s2_r        <= s2_nxt;
      s3_r        <= s3_nxt;
      s4_r        <= s4_nxt;
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      x_r    <= in_tdata[SB-1:0];
      last_r <= in_tlast;
      take_r <= (count_r < CW'(MAX_SAMPLES));
    end
    p_r         <= p_nxt;
    acc_r       <= acc_nxt;
    sgn_r       <= sgn_nxt;
    zero_r      <= zero_nxt;
    out_idx_r   <= out_idx_nxt;
    out_val_r   <= out_val_nxt;
    out_undef_r <= out_undef_nxt;
    out_last_r  <= out_last_nxt;
  end

  // register file: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[ins_r.dst] <= rf_wdata;
    end
    if (state_r == ST_FETCH) begin
      ins_r <= ins_fetch;
      opa_r <= rf_mem[ins_fetch.ra];
      opb_r <= rf_mem[ins_fetch.rb];
    end else begin
      opa_r <= opa_nxt;
      opb_r <= opb_nxt;
    end
  end

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SAMPLES))
    else $error("sample count beyond MAX_SAMPLES");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_EXEC |-> cnt_r == '0)
    else $error("iteration counter left running outside execute");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |-> pc_r <= PROG_LAST)
    else $error("program counter past the end of the program");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[2:0] == IDX_KURT)
    else $error("last result is not the kurtosis");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_SQ)
    else $error("accepted sample did not start accumulation");

endmodule

[bench/testbench.sv]
// Self-checking testbench for the sample moment statistics unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SAMPLES   = 1024;
  localparam int FRACTION_BITS = 16;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 12000;

  typedef logic [255:0] wide_t;

  typedef struct {
    logic [2:0]  index;
    logic [63:0] value;
    logic        undefined;
    logic        last;
  } stat_t;

  typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [11:0] sample
  logic        in_tlast = 1'b0; // last_sample
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [63:0] stat_value
  logic [3:0]  out_tuser;       // [2:0] stat_index, [3] status
  logic        out_tlast;       // last_result

  // Shadow of the block's accumulators.
  int          held_count;
  longint      held_min, held_max;
  longint      power_sum1, power_sum2, power_sum3, power_sum4;

  stat_t       stat_queue[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  idle_mode_t  idle_mode = IDLE_NONE;
  bit          rx_hold_off = 1'b0;

  sample_moment_statistics_unit u_top (.*);

  always #6 clk = ~clk;

  function automatic void clear_sums();
    held_count = 0;
    held_min   = 2047;
    held_max   = -2048;
    power_sum1 = 0;
    power_sum2 = 0;
    power_sum3 = 0;
    power_sum4 = 0;
  endfunction

  function automatic wide_t widen(longint v);
    return {{192{v[63]}}, v};
  endfunction

  function automatic wide_t isqrt(wide_t v);
    wide_t res, b, t;
    res = '0;
    b = wide_t'(1) << 254;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      t = res + b;
      if (v >= t) begin
        v   = v - t;
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Signed numerator over positive denominator, nearest, ties away from zero.
  function automatic wide_t round_div(wide_t num, wide_t den);
    logic  neg;
    wide_t a, q;
    neg = num[255];
    a = neg ? -num : num;
    q = ((a << 1) + den) / (den << 1);
    return neg ? -q : q;
  endfunction

  function automatic void push_stat(int k, wide_t v, logic undef);
    stat_t s;
    s.index     = 3'(k);
    s.value     = undef ? 64'd0 : v[63:0];
    s.undefined = undef;
    s.last      = (k == 6);
    stat_queue.push_back(s);
  endfunction

  // Work out the seven statistics of the set just closed.
  function automatic void predict_statistics();
    longint n;
    wide_t  nw, s1, s2, s3, s4, nn1, d2, d3, d4, d22, num, den, a, v;
    logic   pos, neg;
    n   = held_count;
    nw  = widen(n);
    s1  = widen(power_sum1);
    s2  = widen(power_sum2);
    s3  = widen(power_sum3);
    s4  = widen(power_sum4);
    nn1 = widen(n * (n - 1));
    push_stat(0, widen(held_min * 65536), n < 1);
    push_stat(1, widen(held_max * 65536), n < 1);
    push_stat(2, n >= 1 ? round_div(s1 << FRACTION_BITS, nw) : '0, n < 1);
    d2  = nw * s2 - s1 * s1;
    pos = (n >= 2) && (d2 != 0);
    if (n >= 2) begin
      push_stat(3, round_div(d2 << FRACTION_BITS, nn1), 1'b0);
      v = isqrt((d2 << (2 * FRACTION_BITS + 2)) / nn1);
      push_stat(4, (v + 1) >> 1, 1'b0);
    end else begin
      push_stat(3, '0, 1'b1);
      push_stat(4, '0, 1'b1);
    end
    d3 = nw * nw * s3 - widen(3) * nw * (s1 * s2) + widen(2) * (s1 * (s1 * s1));
    if (n >= 3 && pos) begin
      neg = d3[255];
      a   = neg ? -d3 : d3;
      num = ((a * a) * nn1) << (2 * FRACTION_BITS + 2);
      den = widen((n - 2) * (n - 2)) * d2 * (d2 * d2);
      v   = (isqrt(num / den) + 1) >> 1;
      push_stat(5, neg ? -v : v, 1'b0);
    end else begin
      push_stat(5, '0, 1'b1);
    end
    d4 = (nw * (nw * nw)) * s4;
    d4 = d4 - (widen(4) * (nw * nw)) * (s1 * s3);
    d4 = d4 + (widen(6) * nw) * ((s1 * s1) * s2);
    d4 = d4 - widen(3) * ((s1 * s1) * (s1 * s1));
    if (n >= 4 && pos) begin
      d22 = d2 * d2;
      num = widen((n + 1) * (n - 1)) * d4 - widen(3 * (n - 1) * (n - 1)) * d22;
      den = widen((n - 2) * (n - 3)) * d22;
      push_stat(6, round_div(num << FRACTION_BITS, den), 1'b0);
    end else begin
      push_stat(6, '0, 1'b1);
    end
    clear_sums();
  endfunction

  function automatic void accumulate_sample(logic signed [11:0] s, logic last);
    longint x;
    x = s;
    if (held_count < MAX_SAMPLES) begin
      held_count++;
      if (x < held_min) held_min = x;
      if (x > held_max) held_max = x;
      power_sum1 += x;
      power_sum2 += x * x;
      power_sum3 += x * x * x;
      power_sum4 += x * x * x * x;
    end
    if (last) predict_statistics();
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Offer one sample; hold it until the block takes the transaction.
  task automatic send_sample(logic signed [11:0] s, logic last);
    int pct;
    pct = (idle_mode == IDLE_SENDER) ? 50 : (idle_mode == IDLE_BOTH) ? 16 : 0;
    if ($urandom_range(99) < pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, s};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    accumulate_sample(s, last);
  endtask

  task automatic release_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Pause until every statistic has come, then let the finishing unit go quiet.
  task automatic drain_results();
    release_input();
    while (stat_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [11:0] pick_sample(int flavor);
    unique case (flavor)
      0: return 12'($urandom);
      1: return 12'($signed($urandom_range(0, 16)) - 8);
      2: return $urandom_range(1) ? 12'sh7ff : 12'sh800;
      default: return 12'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  task automatic send_set(int size, int flavor);
    for (int i = 0; i < size; i++) send_sample(pick_sample(flavor), i == size - 1);
  endtask

  // Sets of one to four samples walk through every sample-count limit from variance to kurtosis.
  task automatic test_short_sets();
    send_sample(12'sh7ff, 1'b1);
    send_sample(12'sh800, 1'b0);
    send_sample(12'sh7ff, 1'b1);
    send_sample(12'sh800, 1'b0);
    send_sample(12'sh000, 1'b0);
    send_sample(12'sh7ff, 1'b1);
    send_sample(12'sh800, 1'b0);
    send_sample(12'sh800, 1'b0);
    send_sample(12'sh7ff, 1'b0);
    send_sample(12'sh001, 1'b1);
    drain_results();
  endtask

  // Constant data: variance zero, skewness and kurtosis undefined.
  task automatic test_zero_variance();
    for (int i = 0; i < 5; i++) send_sample(12'sh800, i == 4);
    for (int i = 0; i < 6; i++) send_sample(12'sh7ff, i == 5);
    drain_results();
  endtask

  task automatic test_random_sets();
    int sent;
    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      idle_mode = idle_mode_t'(phase);
      while (sent < 34 * (phase + 1)) begin
        int size;
        size = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        send_set(size, $urandom_range(3));
        sent += size;
      end
      drain_results();
    end
    idle_mode = IDLE_NONE;
  endtask

  // Stall the receiver long enough that the block backs up into its input.
  task automatic test_backpressure();
    fork
      begin
        rx_hold_off = 1'b1;
        repeat (30000) @(posedge clk);
        rx_hold_off = 1'b0;
      end
    join_none
    send_set(6, 0);
    send_set(5, 3);
    send_set(4, 1);
    drain_results();
  endtask

  // Receiver readiness; drop it at random or during a hold-off.
  always @(posedge clk) begin
    int pct;
    pct = (idle_mode == IDLE_RECEIVER) ? 50 : (idle_mode == IDLE_BOTH) ? 16 : 0;
    out_tready <= !rx_hold_off && ($urandom_range(99) >= pct);
  end

  // Check each result transaction against the oldest expected statistic.
  always @(posedge clk) begin
    stat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (stat_queue.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 64'd0);
      end else begin
        want = stat_queue.pop_front();
        if (out_tuser[2:0] !== want.index)
          report_mismatch("stat_index", 64'(out_tuser[2:0]), 64'(want.index));
        if (out_tdata !== want.value)
          report_mismatch("stat_value", out_tdata, want.value);
        if (out_tuser[3] !== want.undefined)
          report_mismatch("status", 64'(out_tuser[3]), 64'(want.undefined));
        if (out_tlast !== want.last)
          report_mismatch("last_result", 64'(out_tlast), 64'(want.last));
      end
    end
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    clear_sums();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_sets();
    test_zero_variance();
    test_random_sets();
    test_backpressure();
    // Let the finishing unit settle before judging leftovers.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (stat_queue.size() != 0) begin
      report_mismatch("statistics never arrived", 64'(stat_queue.size()), 64'd0);
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
design/sms_pkg.sv
design/sample_moment_statistics_unit.sv
bench/testbench.sv
